// ===== rtl/core/rcnf_pkg.sv =====
// Shared types and constants for the register command nibble framer.
// No dependencies; every file but rcnf_if.sv refers to it by scoped names.
package rcnf_pkg;

  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned FRAME_NIBBLES = 16;
  localparam int unsigned NIB_CNT_W     = $clog2(FRAME_NIBBLES);

  localparam logic [NIB_CNT_W-1:0] LAST_NIBBLE = NIB_CNT_W'(FRAME_NIBBLES - 1);

  localparam logic [31:0] HDR_BASE  = 32'h0000_0007;
  localparam logic [31:0] HDR_WRITE = 32'h0000_0010;
  localparam logic [7:0]  TX_MARK   = 8'hF0;
  localparam logic [7:0]  NIB_MASK  = 8'h0F;

  typedef enum logic {
    FUNC_SEND = 1'b0,
    FUNC_RECV = 1'b1
  } func_e;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_REPLY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] word;
  } entry_t;

endpackage

// ===== rtl/core/rcnf_if.sv =====
// Valid/ready channel interfaces for command input and link/reply output.
// Depends on nothing; used by the top level.
interface rcnf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  dev;
  logic [15:0] reg_addr;
  logic        write_flag;
  logic [31:0] wr_data;
  logic [7:0]  rx_byte;

  modport source (output valid, func, dev, reg_addr, write_flag, wr_data, rx_byte,
                  input ready);
  modport sink   (input valid, func, dev, reg_addr, write_flag, wr_data, rx_byte,
                  output ready);
endinterface

interface rcnf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] reply_header;
  logic [31:0] reply_data;

  modport source (output valid, kind, tx_byte, last, reply_header, reply_data,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, reply_header, reply_data,
                  output ready);
endinterface

// ===== rtl/core/rcnf_front.sv =====
// Front end: accepts input words, builds command frames, gathers reply nibbles.
// Depends on rcnf_pkg; pushes entries into rcnf_queue.
module rcnf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [7:0]          dev_i,
  input  logic [15:0]         reg_addr_i,
  input  logic                write_flag_i,
  input  logic [31:0]         wr_data_i,
  input  logic [7:0]          rx_byte_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output rcnf_pkg::entry_t    push_entry_o
);

  logic [rcnf_pkg::NIB_CNT_W-1:0] nib_cnt_q, nib_cnt_d;
  logic [63:0]                    asm_q, asm_d;
  logic [31:0]                    hdr;
  logic [31:0]                    data;
  logic [63:0]                    nib_shifted;
  logic [7:0]                     nib;
  logic                           fire;
  logic                           is_recv;
  logic                           reply_done;

  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_recv    = (func_i == rcnf_pkg::FUNC_RECV);
  assign reply_done = (nib_cnt_q == rcnf_pkg::LAST_NIBBLE);

  assign hdr  = {dev_i, reg_addr_i, 8'h00} | rcnf_pkg::HDR_BASE
              | (write_flag_i ? rcnf_pkg::HDR_WRITE : 32'h0);
  assign data = write_flag_i ? wr_data_i : 32'h0;

  assign nib         = rx_byte_i & rcnf_pkg::NIB_MASK;
  assign nib_shifted = {56'h0, nib} << {nib_cnt_q, 2'b00};

  always_comb begin
    nib_cnt_d = nib_cnt_q;
    asm_d     = asm_q;
    if (fire && is_recv) begin
      nib_cnt_d = nib_cnt_q + 1'b1;
      asm_d     = reply_done ? 64'h0 : (asm_q | nib_shifted);
    end
  end

  always_comb begin
    push_valid_o = in_valid_i && (!is_recv || reply_done);
    if (is_recv) begin
      push_entry_o.kind = rcnf_pkg::KIND_REPLY;
      push_entry_o.word = asm_q | nib_shifted;
    end else begin
      push_entry_o.kind = rcnf_pkg::KIND_TX;
      push_entry_o.word = {data, hdr};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_cnt_q <= '0;
      asm_q     <= '0;
    end else begin
      nib_cnt_q <= nib_cnt_d;
      asm_q     <= asm_d;
    end
  end

endmodule

// ===== rtl/core/rcnf_queue.sv =====
// Short register queue between front and back ends.
// Depends on rcnf_pkg for the entry type.
module rcnf_queue #(
  parameter int unsigned Depth = rcnf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  rcnf_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output rcnf_pkg::entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rcnf_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/rcnf_back.sv =====
// Back end: serializes frames into link bytes and presents completed replies.
// Depends on rcnf_pkg; pops entries from rcnf_queue.
module rcnf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  rcnf_pkg::entry_t pop_entry_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  output logic [31:0]      reply_header_o,
  output logic [31:0]      reply_data_o
);

  logic                           busy_q;
  rcnf_pkg::kind_e                kind_q;
  logic [63:0]                    word_q;
  logic [rcnf_pkg::NIB_CNT_W-1:0] cnt_q;
  logic                           is_tx;
  logic                           fire;
  logic                           finish;

  assign is_tx  = (kind_q == rcnf_pkg::KIND_TX);
  assign fire   = out_valid_o && out_ready_i;
  assign finish = fire && (!is_tx || cnt_q == rcnf_pkg::LAST_NIBBLE);

  assign pop_ready_o    = !busy_q || finish;
  assign out_valid_o    = busy_q;
  assign kind_o         = kind_q;
  assign tx_byte_o      = is_tx ? (rcnf_pkg::TX_MARK | {4'h0, word_q[3:0]}) : 8'h00;
  assign last_o         = is_tx && (cnt_q == rcnf_pkg::LAST_NIBBLE);
  assign reply_header_o = is_tx ? 32'h0 : word_q[31:0];
  assign reply_data_o   = is_tx ? 32'h0 : word_q[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= rcnf_pkg::KIND_TX;
      cnt_q  <= '0;
    end else if (pop_valid_i && pop_ready_o) begin
      busy_q <= 1'b1;
      kind_q <= pop_entry_i.kind;
      cnt_q  <= '0;
    end else if (finish) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      word_q <= pop_entry_i.word;
    end else if (fire) begin
      word_q <= {4'h0, word_q[63:4]};
    end
  end

endmodule

// ===== rtl/core/register_command_nibble_framer_unit.sv =====
// Register command nibble framer: command frames out, reply words back.
// A send word is held in the queue, then in the back end's word register, before
// its first link byte; so is the sixteenth reply byte before the reply word. One
// link byte per cycle unless out_ready stalls; each last byte frees the back end.
// Reset: nibble count and reply assembly cleared, queue emptied, output idle.
module register_command_nibble_framer_unit #(
  parameter int unsigned QueueDepth = rcnf_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcnf_in_if.sink    in_i,
  rcnf_out_if.source out_o
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  rcnf_pkg::entry_t push_entry, pop_entry;

  rcnf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .func_i       (in_i.func),
    .dev_i        (in_i.dev),
    .reg_addr_i   (in_i.reg_addr),
    .write_flag_i (in_i.write_flag),
    .wr_data_i    (in_i.wr_data),
    .rx_byte_i    (in_i.rx_byte),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  rcnf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  rcnf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .kind_o         (out_o.kind),
    .tx_byte_o      (out_o.tx_byte),
    .last_o         (out_o.last),
    .reply_header_o (out_o.reply_header),
    .reply_data_o   (out_o.reply_data)
  );

endmodule

// ===== rtl/core/rcnf_checker.sv =====
// Port-level checks for the register command nibble framer, bound to the top.
// Depends on rcnf_pkg and register_command_nibble_framer_unit.
module rcnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic [7:0]  tx_byte_i,
  input logic        last_i,
  input logic [31:0] reply_header_i,
  input logic [31:0] reply_data_i
);

  logic tx_word;
  logic reply_word;

  assign tx_word    = out_valid_i && (kind_i == rcnf_pkg::KIND_TX);
  assign reply_word = out_valid_i && (kind_i == rcnf_pkg::KIND_REPLY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i)
      && $stable(tx_byte_i) && $stable(last_i)
      && $stable(reply_header_i) && $stable(reply_data_i))
    else $error("output word changed while stalled");

  a_tx_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_word |-> tx_byte_i[7:4] == 4'hF && reply_header_i == 32'h0 && reply_data_i == 32'h0)
    else $error("malformed link byte word");

  a_reply_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_word |-> tx_byte_i == 8'h00 && !last_i)
    else $error("malformed reply word");

  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_word && out_ready_i && !last_i |=> out_valid_i && kind_i == rcnf_pkg::KIND_TX)
    else $error("frame broken before last byte");

endmodule

bind register_command_nibble_framer_unit rcnf_checker u_rcnf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .tx_byte_i      (out_o.tx_byte),
  .last_i         (out_o.last),
  .reply_header_i (out_o.reply_header),
  .reply_data_i   (out_o.reply_data)
);
